// ----- sv/fsktm_pkg.sv -----
// fsktm_pkg: shared types, register indexes, reset values and the sine table
// function for the FSK tone frame modulator. No dependencies.
package fsktm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int STEP_W      = 24;
    localparam int SPB_W       = 10;
    localparam int COUNT_W     = 8;
    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 15;

    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_STEP  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_STEP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPB       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRE_BITS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_POST_BITS = 3'd4;

    localparam logic [STEP_W-1:0]  ONE_STEP_RST  = 24'd6291456;
    localparam logic [STEP_W-1:0]  ZERO_STEP_RST = 24'd4194304;
    localparam logic [SPB_W-1:0]   SPB_RST       = 10'd40;
    localparam logic [COUNT_W-1:0] PRE_BITS_RST  = 8'd40;
    localparam logic [COUNT_W-1:0] POST_BITS_RST = 8'd20;

    localparam int  SINE_AMP = 32767;
    localparam real PI_VAL   = 3.14159265358979323846;

    typedef struct packed {
        logic [STEP_W-1:0]  one_step;
        logic [STEP_W-1:0]  zero_step;
        logic [SPB_W-1:0]   samples_per_bit;
        logic [COUNT_W-1:0] pre_bits;
        logic [COUNT_W-1:0] post_bits;
    } fsktm_cfg_t;

    typedef struct packed {
        logic active;
        logic taken;
        logic bit_value;
        logic frame_end;
    } fsktm_tick_t;

    // trunc(32767*sin(r*ang_step)) for 0 <= r <= q, with ang_step = pi/(2*q)
    function automatic logic [MAG_W-1:0] sine_quarter(input int r, input int q,
                                                      input real ang_step);
        real ang;
        real v;
        ang = ang_step * r;
        v   = SINE_AMP * $sin(ang);
        if (r == 0) begin
            return '0;
        end
        if (r >= q || v >= SINE_AMP) begin
            return MAG_W'(SINE_AMP);
        end
        return MAG_W'($rtoi(v));
    endfunction

endpackage

// ----- sv/fsktm_sine_rom.sv -----
// fsktm_sine_rom: quarter-wave sine ROM with registered read and quadrant
// folding. Depends on fsktm_pkg.
module fsktm_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [TABLE_BITS-1:0]             idx,
    output logic signed [fsktm_pkg::SAMPLE_W-1:0] sample
);
    import fsktm_pkg::*;

    localparam int  QBITS    = TABLE_BITS - 2;
    localparam int  QUARTER  = 1 << QBITS;
    localparam int  DEPTH    = QUARTER + 1;
    localparam int  AW       = QBITS + 1;
    localparam real ANG_STEP = PI_VAL / (2.0 * QUARTER);

    logic [MAG_W-1:0] rom_q [DEPTH];
    logic [QBITS-1:0] r;
    logic [1:0]       quad;
    logic [AW-1:0]    addr;
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;
    logic signed [SAMPLE_W-1:0] mag_s;

    for (genvar k = 0; k < DEPTH; k++) begin : g_rom
        localparam logic [MAG_W-1:0] QV = sine_quarter(k, QUARTER, ANG_STEP);
        assign rom_q[k] = QV;
    end

    assign r    = idx[QBITS-1:0];
    assign quad = idx[TABLE_BITS-1 -: 2];
    assign addr = quad[0] ? (AW'(QUARTER) - {1'b0, r}) : {1'b0, r};

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= rom_q[addr];
            neg_reg <= quad[1];
        end
    end

    assign mag_s  = {1'b0, mag_reg};
    assign sample = neg_reg ? -mag_s : mag_s;

endmodule

// ----- sv/fsktm_ctrl.sv -----
// fsktm_ctrl: frame sequencer (preamble, start bit, data bits, postamble) and
// phase accumulator. Depends on fsktm_pkg.
module fsktm_ctrl #(
    parameter int PHASE_BITS = 24,
    parameter int TABLE_BITS = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          byte_valid,
    input  logic [7:0]                    data_byte,
    input  fsktm_pkg::fsktm_cfg_t         cfg,
    output fsktm_pkg::fsktm_tick_t        tick,
    output logic [TABLE_BITS-1:0]         rom_idx
);
    import fsktm_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_PRE   = 3'd1,
        MODE_START = 3'd2,
        MODE_DATA  = 3'd3,
        MODE_POST  = 3'd4
    } mode_t;

    mode_t                mode_reg, mode_next, mode_cur;
    logic [PHASE_BITS-1:0] phase_reg, phase_next, phase_cur, step_sel;
    logic [SPB_W-1:0]     sib_reg, sib_next, sib_cur, spb_eff;
    logic [COUNT_W-1:0]   bis_reg, bis_next, bis_cur;
    logic [7:0]           shift_reg, shift_next, shift_cur;
    logic [2:0]           bp_reg, bp_next, bp_cur;
    logic                 is_idle, start, bit_val;

    always_comb begin
        is_idle = !(mode_reg == MODE_PRE || mode_reg == MODE_START ||
                    mode_reg == MODE_DATA || mode_reg == MODE_POST);
        start   = is_idle && byte_valid;

        mode_cur  = mode_reg;
        phase_cur = phase_reg;
        sib_cur   = sib_reg;
        bis_cur   = bis_reg;
        shift_cur = shift_reg;
        bp_cur    = bp_reg;
        if (start) begin
            mode_cur  = (cfg.pre_bits != '0) ? MODE_PRE : MODE_START;
            phase_cur = '0;
            sib_cur   = '0;
            bis_cur   = '0;
            shift_cur = data_byte;
            bp_cur    = '0;
        end

        case (mode_cur)
            MODE_START: bit_val = 1'b0;
            MODE_DATA:  bit_val = shift_cur[bp_cur];
            default:    bit_val = 1'b1;
        endcase

        rom_idx  = phase_cur[PHASE_BITS-1 -: TABLE_BITS];
        step_sel = bit_val ? PHASE_BITS'(cfg.one_step) : PHASE_BITS'(cfg.zero_step);
        spb_eff  = (cfg.samples_per_bit == '0) ? SPB_W'(1) : cfg.samples_per_bit;

        tick.active    = !is_idle || byte_valid;
        tick.taken     = start;
        tick.bit_value = tick.active && bit_val;
        tick.frame_end = 1'b0;

        mode_next  = mode_cur;
        phase_next = phase_cur + step_sel;
        sib_next   = sib_cur + SPB_W'(1);
        bis_next   = bis_cur;
        shift_next = shift_cur;
        bp_next    = bp_cur;

        if (tick.active && (sib_next >= spb_eff || sib_next == '0)) begin
            sib_next = '0;
            case (mode_cur)
                MODE_PRE: begin
                    bis_next = bis_cur + COUNT_W'(1);
                    if (bis_next >= cfg.pre_bits || bis_next == '0) begin
                        mode_next  = MODE_START;
                        phase_next = '0;
                    end
                end
                MODE_START: begin
                    mode_next  = MODE_DATA;
                    bp_next    = '0;
                    phase_next = '0;
                end
                MODE_DATA: begin
                    phase_next = '0;
                    bp_next    = bp_cur + 3'd1;
                    if (bp_next == '0) begin
                        if (byte_valid) begin
                            shift_next = data_byte;
                            tick.taken = 1'b1;
                        end else if (cfg.post_bits != '0) begin
                            mode_next = MODE_POST;
                            bis_next  = '0;
                        end else begin
                            tick.frame_end = 1'b1;
                            mode_next      = MODE_IDLE;
                        end
                    end
                end
                default: begin
                    bis_next = bis_cur + COUNT_W'(1);
                    if (bis_next >= cfg.post_bits || bis_next == '0) begin
                        tick.frame_end = 1'b1;
                        mode_next      = MODE_IDLE;
                        phase_next     = '0;
                        bis_next       = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            phase_reg <= '0;
            sib_reg   <= '0;
            bis_reg   <= '0;
            shift_reg <= '0;
            bp_reg    <= '0;
        end else if (en && tick.active) begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            sib_reg   <= sib_next;
            bis_reg   <= bis_next;
            shift_reg <= shift_next;
            bp_reg    <= bp_next;
        end else if (en) begin
            mode_reg  <= MODE_IDLE;
        end
    end

endmodule

// ----- sv/fsk_tone_frame_modulator_unit.sv -----
// fsk_tone_frame_modulator_unit: binary FSK modulator top level, config
// registers, sample pipeline and output register. Depends on fsktm_pkg,
// fsktm_ctrl and fsktm_sine_rom.
//
//  group  | dir | beat content
//  -------+-----+------------------------------------------------------------
//  s_     | in  | one sample tick; tuser = byte_valid, tdata = data_byte
//  m_     | out | one sample; tdata = sample, tuser = flags, tlast = frame_end
//  cfg_   | in  | register write: cfg_index selects, cfg_data is the value
//
// One beat in, one beat out; a new tick is taken every cycle while s_tready is high.
// Pipeline: sequencer and sine ROM read, then output register.
// Reset clears the sequencer and loads the register defaults; no ROM init pass.
// s_tready drops only while both pipeline stages hold data and m_tready is low.
module fsk_tone_frame_modulator_unit #(
    parameter int PHASE_BITS = 24,
    parameter int TABLE_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] data_byte
    input  logic                                s_tuser,   // [0] byte_valid
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // [15:0] sample
    output logic [2:0]                          m_tuser,   // [0] sample_valid [1] byte_taken
                                                           // [2] bit_value
    output logic                                m_tlast,   // frame_end
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fsktm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fsktm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fsktm_pkg::*;

    fsktm_cfg_t            cfg_reg;
    fsktm_tick_t           tick, tick1_reg;
    logic [TABLE_BITS-1:0] rom_idx;
    logic signed [SAMPLE_W-1:0] rom_sample;
    logic                  v1_reg, m_valid_reg, m_load, s_accept;
    logic [SAMPLE_W-1:0]   m_data_reg;
    logic [2:0]            m_user_reg;
    logic                  m_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_step        <= ONE_STEP_RST;
            cfg_reg.zero_step       <= ZERO_STEP_RST;
            cfg_reg.samples_per_bit <= SPB_RST;
            cfg_reg.pre_bits        <= PRE_BITS_RST;
            cfg_reg.post_bits       <= POST_BITS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ONE_STEP:  cfg_reg.one_step        <= cfg_data[STEP_W-1:0];
                CFG_ZERO_STEP: cfg_reg.zero_step       <= cfg_data[STEP_W-1:0];
                CFG_SPB:       cfg_reg.samples_per_bit <= cfg_data[SPB_W-1:0];
                CFG_PRE_BITS:  cfg_reg.pre_bits        <= cfg_data[COUNT_W-1:0];
                CFG_POST_BITS: cfg_reg.post_bits       <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_load   = !m_valid_reg || m_tready;
    assign s_tready = !v1_reg || m_load;
    assign s_accept = s_tvalid && s_tready;

    fsktm_ctrl #(
        .PHASE_BITS(PHASE_BITS),
        .TABLE_BITS(TABLE_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (s_accept),
        .byte_valid (s_tuser),
        .data_byte  (s_tdata),
        .cfg        (cfg_reg),
        .tick       (tick),
        .rom_idx    (rom_idx)
    );

    fsktm_sine_rom #(
        .TABLE_BITS(TABLE_BITS)
    ) u_rom (
        .aclk   (aclk),
        .en     (s_accept),
        .idx    (rom_idx),
        .sample (rom_sample)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                v1_reg <= 1'b1;
            end else if (m_load) begin
                v1_reg <= 1'b0;
            end
            if (m_load) begin
                m_valid_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tick1_reg <= tick;
        end
        if (m_load && v1_reg) begin
            m_data_reg <= tick1_reg.active ? rom_sample : '0;
            m_user_reg <= {tick1_reg.bit_value, tick1_reg.taken, tick1_reg.active};
            m_last_reg <= tick1_reg.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    a_end_is_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("frame end on a beat without a sample");

    a_idle_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && m_tuser[2:1] == 2'b00)
        else $error("idle beat carries data");

    a_stall_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    a_no_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata != 16'h8000)
        else $error("sample out of amplitude range");

endmodule
